>>> rtl/core/cpsp_pkg.sv
package cpsp_pkg;

  localparam int FracBitsDef   = 16;
  localparam int CountWidthDef = 16;
  localparam int GainFrac      = 16;
  localparam int DriveFieldMax = 8191;

  localparam logic [2:0] RegEnable     = 3'd0;
  localparam logic [2:0] RegPosGain    = 3'd1;
  localparam logic [2:0] RegIntGain    = 3'd2;
  localparam logic [2:0] RegSpdNow     = 3'd3;
  localparam logic [2:0] RegSpdPrev    = 3'd4;
  localparam logic [2:0] RegDriveLimit = 3'd5;
  localparam logic [2:0] RegWindow     = 3'd6;
  localparam logic [2:0] RegSettle     = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_PGAIN1,
    ST_PGAIN2,
    ST_INTEG,
    ST_SPEED,
    ST_DRIVE2,
    ST_DRIVE1,
    ST_OUT
  } cpsp_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic zero_out;
    logic step_pos;
    logic step_pgain1;
    logic step_pgain2;
    logic step_integ;
    logic step_speed;
    logic step_drive2;
    logic step_drive1;
    logic present;
  } cpsp_cmd_t;

  typedef struct packed {
    logic clear_req;
    logic enabled;
  } cpsp_status_t;

  typedef struct packed {
    logic        enable;
    logic [23:0] pos_gain;
    logic [23:0] int_gain;
    logic [15:0] spd_now;
    logic [15:0] spd_prev;
    logic [15:0] drive_limit;
    logic [15:0] window;
    logic [7:0]  settle_ticks;
  } cpsp_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/core/cpsp_ctrl.sv
module cpsp_ctrl
  import cpsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  logic         out_busy_i,
  input  cpsp_status_t status_i,
  output logic         idle_o,
  output cpsp_cmd_t    cmd_o
);

  cpsp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    idle_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_POS;
        end
      end
      ST_POS: begin
        if (status_i.clear_req) begin
          cmd_o.clear    = 1'b1;
          cmd_o.zero_out = 1'b1;
          state_d        = ST_OUT;
        end else if (!status_i.enabled) begin
          cmd_o.zero_out = 1'b1;
          state_d        = ST_OUT;
        end else begin
          cmd_o.step_pos = 1'b1;
          state_d        = ST_PGAIN1;
        end
      end
      ST_PGAIN1: begin
        cmd_o.step_pgain1 = 1'b1;
        state_d           = ST_PGAIN2;
      end
      ST_PGAIN2: begin
        cmd_o.step_pgain2 = 1'b1;
        state_d           = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.step_integ = 1'b1;
        state_d          = ST_SPEED;
      end
      ST_SPEED: begin
        cmd_o.step_speed = 1'b1;
        state_d          = ST_DRIVE2;
      end
      ST_DRIVE2: begin
        cmd_o.step_drive2 = 1'b1;
        state_d           = ST_DRIVE1;
      end
      ST_DRIVE1: begin
        cmd_o.step_drive1 = 1'b1;
        state_d           = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.present = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/cpsp_dp.sv
module cpsp_dp
  import cpsp_pkg::*;
#(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cpsp_cmd_t                     cmd_i,
  input  cpsp_cfg_t                     cfg_i,
  input  logic signed [23:0]            ref_i,
  input  logic signed [COUNT_WIDTH-1:0] c1_i,
  input  logic signed [COUNT_WIDTH-1:0] c2_i,
  input  logic                          clr_i,
  output cpsp_status_t                  status_o,
  output logic signed [13:0]            drive_one_o,
  output logic signed [13:0]            drive_two_o,
  output logic signed [31:0]            speed_two_o,
  output logic signed [31:0]            pos_err_two_o,
  output logic signed [31:0]            pos_two_o,
  output logic signed [31:0]            integ_o
);

  localparam longint PosPerCount = ((64'd4 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam longint SpdPerCount = ((64'd400 << FRAC_BITS) + 64'd500) / 64'd1000;

  // Latched item.
  logic signed [23:0]            ref_q;
  logic signed [COUNT_WIDTH-1:0] c1_q, c2_q;
  logic                          clr_q;

  // Persistent controller state.
  logic signed [COUNT_WIDTH-1:0] last1_q, last2_q;
  logic signed [31:0] lerr1_q, lerr2_q, acc1_q, acc2_q, esum_q;
  logic [7:0] settle_q;

  // Working registers.
  logic signed [31:0] p2_q, ep1_q, ep2_q, rv1_q, rv2_q, v2_q;
  logic signed [31:0] e1_q, e2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ref_q <= ref_i;
      c1_q  <= c1_i;
      c2_q  <= c2_i;
      clr_q <= clr_i;
    end
  end

  assign status_o.clear_req = clr_q;
  assign status_o.enabled   = cfg_i.enable;

  // Wide products and sums, 72 bits wide, for the sequencer steps.
  logic signed [71:0] pos1_w, pos2_w, ep1_w, ep2_w, pg_w, ig_w, esum_w, rvi_w;
  logic signed [71:0] v1_w, v2_w, e1_w, e2_w, u_w, u1_w, u2_w, lim_w;
  logic signed [31:0] ep1_n, ep2_n, esum_n, rv2_n, v1_n, e1_n, v2_n, e2_n;
  logic signed [31:0] u1_n, u2_n;
  logic in_win;
  logic settled;
  logic [7:0] settle_n;
  logic [15:0] lim16;

  always_comb begin
    pos1_w = -(72'(c1_q)) * 72'(PosPerCount);
    pos2_w = 72'(c2_q) * 72'(PosPerCount);
    ep1_w  = 72'(ref_q) - 72'(sat32(pos1_w));
    ep2_w  = 72'(ref_q) - 72'(sat32(pos2_w));
    ep1_n  = sat32(ep1_w);
    ep2_n  = sat32(ep2_w);

    pg_w   = 72'($signed({1'b0, cfg_i.pos_gain})) * 72'(ep1_q);
    ig_w   = 72'($signed({1'b0, cfg_i.pos_gain})) * 72'(ep2_q);

    in_win = (72'(ep2_q) > -72'($signed({1'b0, cfg_i.window})))
          && (72'(ep2_q) < 72'($signed({1'b0, cfg_i.window})));
    esum_w = 72'(esum_q) + 72'(ep2_q);
    esum_n = sat32(esum_w);
    rvi_w  = 72'($signed({1'b0, cfg_i.int_gain})) * 72'(esum_n);
    rv2_n  = sat32(72'(rv2_q) + (rvi_w >>> GainFrac));

    v2_w   = (72'(c2_q) - 72'(last2_q)) * 72'(SpdPerCount);
    v1_w   = (72'(last1_q) - 72'(c1_q)) * 72'(SpdPerCount);
    v2_n   = sat32(v2_w);
    v1_n   = sat32(v1_w);
    e2_w   = 72'(rv2_q) - 72'(v2_n);
    e1_w   = 72'(rv1_q) - 72'(v1_n);
    e2_n   = sat32(e2_w);
    e1_n   = sat32(e1_w);

    lim16  = (cfg_i.drive_limit > 16'(DriveFieldMax)) ? 16'(DriveFieldMax)
                                                       : cfg_i.drive_limit;
    lim_w  = 72'($signed({1'b0, lim16}));

    u_w    = 72'($signed({1'b0, cfg_i.spd_now})) * 72'(e2_q)
           - 72'($signed({1'b0, cfg_i.spd_prev})) * 72'(lerr2_q);
    u2_w   = 72'(acc2_q) + (u_w >>> FRAC_BITS);
    if (u2_w > lim_w) u2_w = lim_w;
    else if (u2_w < -lim_w) u2_w = -lim_w;
    u2_n   = u2_w[31:0];

    u1_w   = 72'(acc1_q) + ((72'($signed({1'b0, cfg_i.spd_now})) * 72'(e1_q)
           - 72'($signed({1'b0, cfg_i.spd_prev})) * 72'(lerr1_q)) >>> FRAC_BITS);
    settled  = (e1_q == '0) && (lerr1_q == '0) && (ep1_q == '0);
    settle_n = (settle_q != 8'hff) ? settle_q + 8'd1 : settle_q;
    if (settled && (settle_n > cfg_i.settle_ticks)) u1_w = '0;
    if (u1_w > lim_w) u1_w = lim_w;
    else if (u1_w < -lim_w) u1_w = -lim_w;
    u1_n   = u1_w[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last1_q  <= '0;
      last2_q  <= '0;
      lerr1_q  <= '0;
      lerr2_q  <= '0;
      acc1_q   <= '0;
      acc2_q   <= '0;
      esum_q   <= '0;
      settle_q <= '0;
    end else if (cmd_i.clear) begin
      last1_q  <= '0;
      last2_q  <= '0;
      lerr1_q  <= '0;
      lerr2_q  <= '0;
      acc1_q   <= '0;
      acc2_q   <= '0;
      esum_q   <= '0;
      settle_q <= '0;
    end else begin
      if (cmd_i.step_integ && in_win) esum_q <= esum_n;
      if (cmd_i.step_drive2) begin
        acc2_q  <= u2_n;
        lerr2_q <= e2_q;
        last2_q <= c2_q;
      end
      if (cmd_i.step_drive1) begin
        acc1_q  <= u1_n;
        lerr1_q <= e1_q;
        last1_q <= c1_q;
        if (settled) settle_q <= settle_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_pos) begin
      p2_q  <= sat32(pos2_w);
      ep1_q <= ep1_n;
      ep2_q <= ep2_n;
    end
    if (cmd_i.step_pgain1) rv1_q <= sat32(pg_w >>> GainFrac);
    if (cmd_i.step_pgain2) rv2_q <= sat32(ig_w >>> GainFrac);
    if (cmd_i.step_integ && in_win) rv2_q <= rv2_n;
    if (cmd_i.step_speed) begin
      v2_q <= v2_n;
      e2_q <= e2_n;
      e1_q <= e1_n;
    end
    if (cmd_i.zero_out) begin
      drive_one_o   <= '0;
      drive_two_o   <= '0;
      speed_two_o   <= '0;
      pos_err_two_o <= '0;
      pos_two_o     <= '0;
      integ_o       <= '0;
    end
    if (cmd_i.step_drive2) drive_two_o <= u2_n[13:0];
    if (cmd_i.step_drive1) begin
      drive_one_o   <= u1_n[13:0];
      speed_two_o   <= v2_q;
      pos_err_two_o <= ep2_q;
      pos_two_o     <= p2_q;
      integ_o       <= esum_q;
    end
  end

endmodule

>>> rtl/core/cpsp_regs.sv
module cpsp_regs
  import cpsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output cpsp_cfg_t   cfg_o
);

  cpsp_cfg_t  cfg_q;
  logic [2:0] idx;

  assign idx   = paddr_i[4:2];
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.pos_gain     <= 24'd65536;
      cfg_q.int_gain     <= 24'd0;
      cfg_q.spd_now      <= 16'd1245;
      cfg_q.spd_prev     <= 16'd996;
      cfg_q.drive_limit  <= 16'd6000;
      cfg_q.window       <= 16'd6554;
      cfg_q.settle_ticks <= 8'd10;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[1:0] == 2'b00)) begin
      case (idx)
        RegEnable:     cfg_q.enable       <= pwdata_i[0];
        RegPosGain:    cfg_q.pos_gain     <= pwdata_i[23:0];
        RegIntGain:    cfg_q.int_gain     <= pwdata_i[23:0];
        RegSpdNow:     cfg_q.spd_now      <= pwdata_i[15:0];
        RegSpdPrev:    cfg_q.spd_prev     <= pwdata_i[15:0];
        RegDriveLimit: cfg_q.drive_limit  <= pwdata_i[15:0];
        RegWindow:     cfg_q.window       <= pwdata_i[15:0];
        RegSettle:     cfg_q.settle_ticks <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegEnable:     prdata_o = {31'd0, cfg_q.enable};
      RegPosGain:    prdata_o = {8'd0, cfg_q.pos_gain};
      RegIntGain:    prdata_o = {8'd0, cfg_q.int_gain};
      RegSpdNow:     prdata_o = {16'd0, cfg_q.spd_now};
      RegSpdPrev:    prdata_o = {16'd0, cfg_q.spd_prev};
      RegDriveLimit: prdata_o = {16'd0, cfg_q.drive_limit};
      RegWindow:     prdata_o = {16'd0, cfg_q.window};
      RegSettle:     prdata_o = {24'd0, cfg_q.settle_ticks};
      default:       prdata_o = '0;
    endcase
  end

endmodule

>>> rtl/core/cascaded_position_speed_pi.sv
// Cascaded position and speed PI controller for two motors, one control tick per word.
// The slave stream carries one tick: reference angle, both encoder counts and a clear
// flag in tuser. The master stream returns one word per tick with both drives in
// millivolts and the motor 2 speed, position error, position and error sum.
// Registers must be written by the user through the APB-style port while no tick
// is in flight; the block itself does not enforce this. A tick is taken only when
// the block is idle. An enabled tick runs through eight sequencer steps before its
// word shows tvalid on the master side. A tick with the clear flag set, or one that
// arrives while the controller is disabled, goes straight from the position step to
// the output step and yields its zero word. The sequencer returns to idle at the
// edge that loads the word, so it takes no new tick before the last word is loaded.
// The result sits in an output register. If the receiver stalls, the block holds it;
// one further tick may be accepted and computed meanwhile, after which the sequencer
// waits in its last step and takes nothing more until the held word has gone.
// Reset clears the controller state, restores register defaults and empties the
// output register. A clear flag in a tick zeroes the state and yields a zero word.
module cascaded_position_speed_pi
  import cpsp_pkg::*;
#(
  parameter int FRAC_BITS   = FracBitsDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: reference_angle[23:0], count_one, count_two, zero padding
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((24 + 2 * COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: clear_state
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: drive_one[13:0], drive_two[27:14], speed_two, pos_error_two,
  // position_two, integral_out, zero padding
  output logic [159:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cpsp_cmd_t    cmd;
  cpsp_status_t status;
  cpsp_cfg_t    cfg;
  logic         idle;
  logic         in_fire;
  logic         out_valid_q;

  logic signed [13:0] d1, d2;
  logic signed [31:0] sp2, pe2, ps2, ie;

  assign pready        = 1'b1;
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  cpsp_regs u_regs (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .prdata_o(prdata), .cfg_o(cfg)
  );

  cpsp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .out_busy_i(out_valid_q && !m_axis_tready),
    .status_i(status),
    .idle_o(idle),
    .cmd_o(cmd)
  );

  cpsp_dp #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cfg_i(cfg),
    .ref_i(s_axis_tdata[23:0]),
    .c1_i(s_axis_tdata[24 +: COUNT_WIDTH]),
    .c2_i(s_axis_tdata[24 + COUNT_WIDTH +: COUNT_WIDTH]),
    .clr_i(s_axis_tuser),
    .status_o(status),
    .drive_one_o(d1), .drive_two_o(d2), .speed_two_o(sp2),
    .pos_err_two_o(pe2), .pos_two_o(ps2), .integ_o(ie)
  );

  // Output word register, loaded as the sequence presents a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.present) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.present) begin
      m_axis_tdata <= {4'd0, ie, ps2, pe2, sp2, d2, d1};
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

>>> rtl/core/cpsp_checker.sv
module cpsp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted during a tick");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result word present too soon");

endmodule

bind cascaded_position_speed_pi cpsp_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the cascaded position and speed PI controller.
// Ticks go in on the slave stream. A scoreboard predicts the result word of each
// accepted tick and compares every word that leaves the master stream against
// the oldest prediction. The run is split into phases with different register
// settings and different idling patterns on both streams.

class pi_scoreboard;

  typedef struct {
    logic [13:0] drive_one;
    logic [13:0] drive_two;
    logic [31:0] speed_two;
    logic [31:0] pos_error_two;
    logic [31:0] position_two;
    logic [31:0] integral_out;
  } ctrl_word_t;

  // Register copies.
  bit          enable;
  longint      pos_gain, int_gain, gain_now, gain_prev, drive_lim, window, settle_lim;
  // Controller state.
  longint      prev_c1, prev_c2, prev_err1, prev_err2, acc1, acc2, err_sum;
  int          settle_cnt;
  ctrl_word_t  pending[$];
  int          fails;

  function new();
    enable     = 0;
    pos_gain   = 65536;
    int_gain   = 0;
    gain_now   = 1245;
    gain_prev  = 996;
    drive_lim  = 6000;
    window     = 6554;
    settle_lim = 10;
    fails      = 0;
    wipe();
  endfunction

  function void wipe();
    prev_c1    = 0;
    prev_c2    = 0;
    prev_err1  = 0;
    prev_err2  = 0;
    acc1       = 0;
    acc2       = 0;
    err_sum    = 0;
    settle_cnt = 0;
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint bound(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Predicts the word for one accepted tick and queues it.
  function void note_tick(logic signed [23:0] ang, logic signed [15:0] cnt1,
                          logic signed [15:0] cnt2, bit clr);
    longint r, c1, c2, p1, p2, ep1, ep2, rv1, rv2, v1, v2, e1, e2, u1, u2, lim;
    ctrl_word_t w;
    w = '{default: '0};
    if (clr) begin
      wipe();
      pending.push_back(w);
      return;
    end
    if (!enable) begin
      pending.push_back(w);
      return;
    end
    r  = ang;
    c1 = cnt1;
    c2 = cnt2;
    p1  = clip32(-c1 * 262);
    p2  = clip32(c2 * 262);
    ep1 = clip32(r - p1);
    ep2 = clip32(r - p2);
    // Arithmetic right shift on a longint floors, as the fixed point needs.
    rv1 = clip32((pos_gain * ep1) >>> 16);
    rv2 = clip32((pos_gain * ep2) >>> 16);
    // The integral only runs while the error is strictly inside the window.
    if (ep2 > -window && ep2 < window) begin
      err_sum = clip32(err_sum + ep2);
      rv2     = clip32(rv2 + ((int_gain * err_sum) >>> 16));
    end
    v2 = clip32((c2 - prev_c2) * 26214);
    v1 = clip32((prev_c1 - c1) * 26214);
    e2 = clip32(rv2 - v2);
    e1 = clip32(rv1 - v1);
    lim = (drive_lim > 8191) ? 8191 : drive_lim;
    u2 = bound(acc2 + ((gain_now * e2 - gain_prev * prev_err2) >>> 16), lim);
    u1 = acc1 + ((gain_now * e1 - gain_prev * prev_err1) >>> 16);
    if (e1 == 0 && prev_err1 == 0 && ep1 == 0) begin
      if (settle_cnt < 255) settle_cnt++;
      if (settle_cnt > settle_lim) u1 = 0;
    end
    u1 = bound(u1, lim);
    prev_c1   = c1;
    prev_c2   = c2;
    prev_err1 = e1;
    prev_err2 = e2;
    acc1      = u1;
    acc2      = u2;
    w.drive_one     = u1[13:0];
    w.drive_two     = u2[13:0];
    w.speed_two     = v2[31:0];
    w.pos_error_two = ep2[31:0];
    w.position_two  = p2[31:0];
    w.integral_out  = err_sum[31:0];
    pending.push_back(w);
  endfunction

  function void check_word(logic [159:0] d);
    ctrl_word_t w;
    if (pending.size() == 0) begin
      $error("result word with no prediction waiting: %h", d);
      fails++;
      return;
    end
    w = pending.pop_front();
    if (d[13:0] !== w.drive_one) begin
      $error("drive_one expected %0d got %0d", $signed(w.drive_one), $signed(d[13:0]));
      fails++;
    end
    if (d[27:14] !== w.drive_two) begin
      $error("drive_two expected %0d got %0d", $signed(w.drive_two), $signed(d[27:14]));
      fails++;
    end
    if (d[59:28] !== w.speed_two) begin
      $error("speed_two expected %0d got %0d", $signed(w.speed_two), $signed(d[59:28]));
      fails++;
    end
    if (d[91:60] !== w.pos_error_two) begin
      $error("pos_error_two expected %0d got %0d", $signed(w.pos_error_two),
             $signed(d[91:60]));
      fails++;
    end
    if (d[123:92] !== w.position_two) begin
      $error("position_two expected %0d got %0d", $signed(w.position_two),
             $signed(d[123:92]));
      fails++;
    end
    if (d[155:124] !== w.integral_out) begin
      $error("integral_out expected %0d got %0d", $signed(w.integral_out),
             $signed(d[155:124]));
      fails++;
    end
  endfunction

endclass

module tb_top
  import cpsp_pkg::*;
();

  localparam int WatchLimit = 5000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tdata: reference_angle[23:0], count_one[39:24], count_two[55:40]
  logic [55:0]  s_axis_tdata;
  // tuser: clear_state
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: drive_one, drive_two, speed_two, pos_error_two, position_two,
  // integral_out, zero padding
  logic [159:0] m_axis_tdata;
  logic         psel, penable, pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  pi_scoreboard tick_board;
  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both idle.
  int           idle_mode;
  int           quiet_cycles;
  // State of a steady run: a stretch of ticks around a settled position.
  int           steady_left;
  logic signed [15:0] steady_c1, steady_c2;
  logic signed [23:0] steady_ang;

  cascaded_position_speed_pi dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The receiver decides its stall afresh at every falling edge.
  always @(negedge clk_i) begin
    if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 79);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 33);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result words are checked at the rising edge that accepts them, and the
  // watchdog counts edges at which neither stream nor the register port moves.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tick_board.check_word(m_axis_tdata);
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("** cascaded_position_speed_pi: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      RegEnable:     tick_board.enable     = value[0];
      RegPosGain:    tick_board.pos_gain   = value[23:0];
      RegIntGain:    tick_board.int_gain   = value[23:0];
      RegSpdNow:     tick_board.gain_now   = value[15:0];
      RegSpdPrev:    tick_board.gain_prev  = value[15:0];
      RegDriveLimit: tick_board.drive_lim  = value[15:0];
      RegWindow:     tick_board.window     = value[15:0];
      RegSettle:     tick_board.settle_lim = value[7:0];
      default: ;
    endcase
  endtask

  // Offers one tick word and returns once it has been accepted.
  task automatic send_tick(input logic signed [23:0] ang, input logic signed [15:0] c1,
                           input logic signed [15:0] c2, input bit clr);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 79 : ((idle_mode == 3) ? 33 : 0);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {c2, c1, ang};
    s_axis_tuser  = clr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tick_board.note_tick(ang, c1, c2, clr);
    // At the next falling edge the next call offers its word or lowers tvalid, or settle() lowers it.
  endtask

  // Waits until every predicted word has arrived and the block has gone idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tick_board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Picks the next random tick. Most ticks belong to steady runs around a
  // position where motor 1 sits exactly on target, which drives the settle
  // counter and keeps motor 2 close to its target, mostly inside the integration window.
  task automatic next_tick(output logic signed [23:0] ang, output logic signed [15:0] c1,
                           output logic signed [15:0] c2, output bit clr);
    int pick;
    clr  = ($urandom_range(0, 59) == 0);
    pick = $urandom_range(0, 99);
    if (steady_left == 0 && pick < 30) begin
      ang = 24'($urandom);
      c1  = 16'($urandom);
      c2  = 16'($urandom);
      return;
    end
    if (steady_left == 0) begin
      steady_left = $urandom_range(6, 30);
      steady_c1   = 16'($signed($urandom_range(0, 4000)) - 2000);
      steady_ang  = 24'(-steady_c1 * 262);
      steady_c2   = -steady_c1;
    end
    steady_left--;
    // Motor 2 wobbles by a count or two, now and then a bigger jump.
    if ($urandom_range(0, 9) == 0) begin
      c2 = 16'(steady_c2 + $signed($urandom_range(0, 200)) - 100);
    end else begin
      c2 = 16'(steady_c2 + $signed($urandom_range(0, 4)) - 2);
    end
    c1  = ($urandom_range(0, 19) == 0) ? 16'(steady_c1 + 1) : steady_c1;
    ang = steady_ang;
  endtask

  task automatic apply_phase(input int ph);
    case (ph)
      0: begin
        write_reg(RegEnable, 1);
        write_reg(RegPosGain, 65536);
        write_reg(RegIntGain, 0);
        write_reg(RegSpdNow, 1245);
        write_reg(RegSpdPrev, 996);
        write_reg(RegDriveLimit, 6000);
        write_reg(RegWindow, 6554);
        write_reg(RegSettle, 10);
      end
      1: begin
        write_reg(RegPosGain, 24'hffffff);
        write_reg(RegIntGain, 24'hffffff);
        write_reg(RegSpdNow, 16'hffff);
        write_reg(RegSpdPrev, 16'hffff);
        write_reg(RegDriveLimit, 8191);
        write_reg(RegWindow, 16'hffff);
        write_reg(RegSettle, 255);
      end
      2: begin
        write_reg(RegPosGain, 0);
        write_reg(RegIntGain, 0);
        write_reg(RegSpdNow, 0);
        write_reg(RegSpdPrev, 0);
        write_reg(RegDriveLimit, 0);
        write_reg(RegWindow, 0);
        write_reg(RegSettle, 0);
      end
      3: begin
        write_reg(RegPosGain, 65536);
        write_reg(RegIntGain, 4000);
        write_reg(RegSpdNow, 1245);
        write_reg(RegSpdPrev, 996);
        write_reg(RegDriveLimit, 16'hffff);
        write_reg(RegWindow, 6554);
        write_reg(RegSettle, 0);
      end
      4: write_reg(RegEnable, 0);
      default: begin
        write_reg(RegEnable, 1);
        write_reg(RegPosGain, $urandom_range(0, 300000));
        write_reg(RegIntGain, $urandom_range(0, 20000));
        write_reg(RegSpdNow, $urandom_range(0, 65535));
        write_reg(RegSpdPrev, $urandom_range(0, 65535));
        write_reg(RegDriveLimit, $urandom_range(0, 65535));
        write_reg(RegWindow, $urandom_range(0, 65535));
        write_reg(RegSettle, $urandom_range(0, 20));
      end
    endcase
  endtask

  initial begin
    logic signed [23:0] ang;
    logic signed [15:0] c1, c2;
    bit                 clr;
    tick_board    = new();
    idle_mode     = 0;
    quiet_cycles  = 0;
    steady_left   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The controller starts disabled, so these give zero words.
    send_tick(24'sh7fffff, 16'sh7fff, -16'sd32768, 1'b0);
    send_tick(-24'sd8388608, -16'sd32768, 16'sh7fff, 1'b0);
    settle();
    apply_phase(0);
    send_tick(24'sh7fffff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_tick(-24'sd8388608, -16'sd32768, -16'sd32768, 1'b0);
    send_tick(24'sh7fffff, -16'sd32768, -16'sd32768, 1'b0);
    send_tick(-24'sd8388608, 16'sh7fff, 16'sh7fff, 1'b0);
    send_tick(0, 0, 0, 1'b1);
    send_tick(100, 0, 0, 1'b0);
    // Motor 1 held exactly on target long enough for its drive to be forced off.
    for (int i = 0; i < 14; i++) send_tick(-24'sd2620, 16'sd10, -16'sd10, 1'b0);
    settle();

    // Random part, phase by phase.
    for (int ph = 0; ph < 10; ph++) begin
      apply_phase(ph);
      idle_mode   = ph % 4;
      steady_left = 0;
      for (int n = 0; n < 130; n++) begin
        // Once in the run the sender holds off until the block has drained.
        if (ph == 6 && n == 65) settle();
        next_tick(ang, c1, c2, clr);
        send_tick(ang, c1, c2, clr);
      end
      settle();
    end

    idle_mode = 0;
    settle();
    if (tick_board.fails == 0) begin
      $display("** cascaded_position_speed_pi: PASSED **");
    end else begin
      $display("** cascaded_position_speed_pi: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cpsp_pkg.sv
rtl/core/cpsp_ctrl.sv
rtl/core/cpsp_dp.sv
rtl/core/cpsp_regs.sv
rtl/core/cascaded_position_speed_pi.sv
rtl/core/cpsp_checker.sv
test/tb_top.sv
